FILE: rtl/ncbt_pkg.sv
// Package of types, constants and sizes for the nearest-centroid blob tracker.
`default_nettype none
package ncbt_pkg;

  localparam int unsigned MaxTracks = 16;
  localparam int unsigned IdxW = $clog2(MaxTracks);
  localparam int unsigned CntW = $clog2(MaxTracks + 1);

  localparam int unsigned CoordW = 13;
  localparam int unsigned IdentW = 32;
  localparam int unsigned FramesW = 16;
  localparam int unsigned SqW = 2 * CoordW;
  localparam int unsigned DistW = SqW + 1;

  localparam logic [CoordW-1:0] RadiusReset = CoordW'(1600);

  localparam logic OpBlob = 1'b0;
  localparam logic OpEndFrame = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [IdentW-1:0]  ident;
    logic [FramesW-1:0] frames;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/nearest_centroid_blob_tracker_top.sv
// Top level of the nearest-centroid blob tracker: entry memory, scan pipeline and control.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | opcode_i, centroid_x_i, centroid_y_i
//   out     | output    | out_valid_o / out_stall_i | track_id_o, is_new_o, frames_seen_o,
//           |           |                           | table_full_o, live_count_o, removed_count_o
//   cfg     | input     | cfg_we_i                  | cfg_data_i (match radius)
//
// A request holds the block from acceptance through one entry memory read per live tracker
// plus a bound check, a drain of the two pipeline stages, and a write back that registers
// the result.
// Reset clears the live count, matched marks, id counter and output valid; radius returns to 1600 px.
// The next request is taken while the previous result waits; a request finishing while the
// output register is still held by out_stall_i waits in its last cycle.
`default_nettype none
module nearest_centroid_blob_tracker_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ncbt_pkg::CoordW-1:0]      cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             opcode_i,
  input  wire logic [ncbt_pkg::CoordW-1:0]      centroid_x_i,
  input  wire logic [ncbt_pkg::CoordW-1:0]      centroid_y_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [ncbt_pkg::IdentW-1:0]           track_id_o,
  output logic                                  is_new_o,
  output logic [ncbt_pkg::FramesW-1:0]          frames_seen_o,
  output logic                                  table_full_o,
  output logic [4:0]                            live_count_o,
  output logic [4:0]                            removed_count_o
);

  localparam int unsigned IdxW = ncbt_pkg::IdxW;
  localparam int unsigned CntW = ncbt_pkg::CntW;
  localparam int unsigned CoordW = ncbt_pkg::CoordW;
  localparam int unsigned SqW = ncbt_pkg::SqW;
  localparam int unsigned DistW = ncbt_pkg::DistW;
  localparam int unsigned IdentW = ncbt_pkg::IdentW;
  localparam int unsigned FramesW = ncbt_pkg::FramesW;

  // entry memory
  ncbt_pkg::entry_t mem [ncbt_pkg::MaxTracks];
  ncbt_pkg::entry_t rdata_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  ncbt_pkg::entry_t mem_wdata;

  ncbt_pkg::state_e state_q, state_d;

  logic [SqW-1:0]       r2_q;
  logic [CntW-1:0]      count_q;
  logic [ncbt_pkg::MaxTracks-1:0] matched_q;
  logic [IdentW-1:0]    next_id_q;

  logic                 op_q;
  logic [CoordW-1:0]    cx_q, cy_q;
  logic [CntW-1:0]      idx_q;
  logic [CntW-1:0]      wr_idx_q;

  logic                 p1_vld_q;
  logic [IdxW-1:0]      p1_idx_q;
  logic                 p2_vld_q;
  logic [IdxW-1:0]      p2_idx_q;
  logic [SqW-1:0]       p2_sqx_q, p2_sqy_q;
  logic [IdentW-1:0]    p2_ident_q;
  logic [FramesW-1:0]   p2_frames_q;

  logic                 best_found_q;
  logic [DistW-1:0]     best_d_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [IdentW-1:0]    best_ident_q;
  logic [FramesW-1:0]   best_frames_q;

  logic                 out_valid_q;
  logic [IdentW-1:0]    track_id_q;
  logic                 is_new_q;
  logic [FramesW-1:0]   frames_q;
  logic                 full_q;
  logic [4:0]           live_q;
  logic [4:0]           removed_q;

  logic                 in_acc;
  logic                 scan_rd;
  logic                 fin_go;

  logic [CoordW-1:0]    dx, dy;
  logic [DistW-1:0]     dist_sum;
  logic                 keep_p1;
  logic                 hit;
  logic                 room;
  logic [FramesW-1:0]   frames_inc;

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ncbt_pkg::ST_IDLE:   if (in_valid_i) state_d = ncbt_pkg::ST_SCAN;
      ncbt_pkg::ST_SCAN:   if (idx_q >= count_q) state_d = ncbt_pkg::ST_DRAIN;
      ncbt_pkg::ST_DRAIN:  if (!p1_vld_q && !p2_vld_q) state_d = ncbt_pkg::ST_FINISH;
      ncbt_pkg::ST_FINISH: if (!out_valid_q || !out_stall_i) state_d = ncbt_pkg::ST_IDLE;
      default:             state_d = ncbt_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    scan_rd    = 1'b0;
    fin_go     = 1'b0;
    unique case (state_q)
      ncbt_pkg::ST_IDLE:   in_stall_o = 1'b0;
      ncbt_pkg::ST_SCAN:   scan_rd = (idx_q < count_q);
      ncbt_pkg::ST_DRAIN:  ;
      ncbt_pkg::ST_FINISH: fin_go = !out_valid_q || !out_stall_i;
      default:             ;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // stage 1: distance terms; stage 2: sum and compare
  assign dx = (rdata_q.x > cx_q) ? (rdata_q.x - cx_q) : (cx_q - rdata_q.x);
  assign dy = (rdata_q.y > cy_q) ? (rdata_q.y - cy_q) : (cy_q - rdata_q.y);
  assign dist_sum = DistW'(p2_sqx_q) + DistW'(p2_sqy_q);
  assign keep_p1 = p1_vld_q && matched_q[p1_idx_q];

  assign hit  = best_found_q && (best_d_q < DistW'(r2_q));
  assign room = count_q < CntW'(ncbt_pkg::MaxTracks);
  assign frames_inc = (&best_frames_q) ? best_frames_q : best_frames_q + FramesW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx_q[IdxW-1:0];
    mem_wdata = rdata_q;
    if (op_q == ncbt_pkg::OpEndFrame) begin
      mem_we = keep_p1;
    end else if (fin_go) begin
      if (hit) begin
        mem_we    = 1'b1;
        mem_waddr = best_idx_q;
        mem_wdata = '{x: cx_q, y: cy_q, ident: best_ident_q, frames: frames_inc};
      end else if (room) begin
        mem_we    = 1'b1;
        mem_waddr = count_q[IdxW-1:0];
        mem_wdata = '{x: cx_q, y: cy_q, ident: next_id_q, frames: '0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[idx_q[IdxW-1:0]];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ncbt_pkg::ST_IDLE;
      r2_q         <= SqW'(ncbt_pkg::RadiusReset) * SqW'(ncbt_pkg::RadiusReset);
      count_q      <= '0;
      matched_q    <= '0;
      next_id_q    <= '0;
      p1_vld_q     <= 1'b0;
      p2_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= scan_rd;
      p2_vld_q <= p1_vld_q && (op_q == ncbt_pkg::OpBlob) && !matched_q[p1_idx_q];
      if (cfg_we_i) begin
        r2_q <= SqW'(cfg_data_i) * SqW'(cfg_data_i);
      end
      if (in_acc) begin
        best_found_q <= 1'b0;
      end else if (p2_vld_q && (!best_found_q || dist_sum < best_d_q)) begin
        best_found_q <= 1'b1;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
        if (op_q == ncbt_pkg::OpEndFrame) begin
          count_q   <= wr_idx_q;
          matched_q <= '0;
        end else if (hit) begin
          matched_q[best_idx_q] <= 1'b1;
        end else if (room) begin
          matched_q[count_q[IdxW-1:0]] <= 1'b1;
          count_q   <= count_q + CntW'(1);
          next_id_q <= next_id_q + IdentW'(1);
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= opcode_i;
      cx_q     <= centroid_x_i;
      cy_q     <= centroid_y_i;
      idx_q    <= '0;
      wr_idx_q <= '0;
    end else begin
      if (scan_rd) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (op_q == ncbt_pkg::OpEndFrame && keep_p1) begin
        wr_idx_q <= wr_idx_q + CntW'(1);
      end
    end
    p1_idx_q    <= idx_q[IdxW-1:0];
    p2_idx_q    <= p1_idx_q;
    p2_sqx_q    <= SqW'(dx) * SqW'(dx);
    p2_sqy_q    <= SqW'(dy) * SqW'(dy);
    p2_ident_q  <= rdata_q.ident;
    p2_frames_q <= rdata_q.frames;
    if (p2_vld_q && (!best_found_q || dist_sum < best_d_q)) begin
      best_d_q      <= dist_sum;
      best_idx_q    <= p2_idx_q;
      best_ident_q  <= p2_ident_q;
      best_frames_q <= p2_frames_q;
    end
    if (fin_go) begin
      if (op_q == ncbt_pkg::OpEndFrame) begin
        track_id_q <= '0;
        is_new_q   <= 1'b0;
        frames_q   <= '0;
        full_q     <= 1'b0;
        live_q     <= 5'(wr_idx_q);
        removed_q  <= 5'(count_q - wr_idx_q);
      end else if (hit) begin
        track_id_q <= best_ident_q;
        is_new_q   <= 1'b0;
        frames_q   <= frames_inc;
        full_q     <= 1'b0;
        live_q     <= 5'(count_q);
        removed_q  <= '0;
      end else if (room) begin
        track_id_q <= next_id_q;
        is_new_q   <= 1'b1;
        frames_q   <= '0;
        full_q     <= 1'b0;
        live_q     <= 5'(count_q + CntW'(1));
        removed_q  <= '0;
      end else begin
        track_id_q <= '0;
        is_new_q   <= 1'b0;
        frames_q   <= '0;
        full_q     <= 1'b1;
        live_q     <= 5'(count_q);
        removed_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign track_id_o      = track_id_q;
  assign is_new_o        = is_new_q;
  assign frames_seen_o   = frames_q;
  assign table_full_o    = full_q;
  assign live_count_o    = live_q;
  assign removed_count_o = removed_q;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the nearest-centroid blob tracker: predicts every result and compares in order.
module tb_top;
  import ncbt_pkg::*;

  localparam int CoordMax = (1 << CoordW) - 1;

  typedef struct packed {
    logic [IdentW-1:0]  track_id;
    logic               is_new;
    logic [FramesW-1:0] frames_seen;
    logic               table_full;
    logic [4:0]         live_count;
    logic [4:0]         removed_count;
  } track_result_t;

  class track_scoreboard;
    logic [CoordW-1:0] radius;
    entry_t            slots[MaxTracks];
    bit                live[MaxTracks];
    bit                matched[MaxTracks];
    logic [IdentW-1:0] next_ident;
    track_result_t     expected_q[$];
    int                errors;

    function new();
      radius = RadiusReset;
      next_ident = '0;
      errors = 0;
      foreach (slots[i]) begin
        slots[i] = '0;
        live[i] = 1'b0;
        matched[i] = 1'b0;
      end
    endfunction

    function int live_total();
      int n;
      n = 0;
      foreach (live[i]) if (live[i]) n++;
      return n;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic op, logic [CoordW-1:0] cx, logic [CoordW-1:0] cy);
      track_result_t   r;
      int              best;
      int              keep;
      int              live_prior;
      longint unsigned best_d;
      longint unsigned d;
      longint unsigned dx;
      longint unsigned dy;
      r = '0;
      if (op == OpBlob) begin
        best = -1;
        best_d = 0;
        for (int i = 0; i < MaxTracks; i++) begin
          if (live[i] && !matched[i]) begin
            dx = (slots[i].x > cx) ? 64'(slots[i].x - cx) : 64'(cx - slots[i].x);
            dy = (slots[i].y > cy) ? 64'(slots[i].y - cy) : 64'(cy - slots[i].y);
            d = dx * dx + dy * dy;
            // strict compare keeps the earliest tracker on ties
            if (best < 0 || d < best_d) begin
              best = i;
              best_d = d;
            end
          end
        end
        if (best >= 0 && best_d < 64'(radius) * 64'(radius)) begin
          slots[best].x = cx;
          slots[best].y = cy;
          matched[best] = 1'b1;
          if (slots[best].frames != '1) slots[best].frames = slots[best].frames + 1'b1;
          r.track_id = slots[best].ident;
          r.frames_seen = slots[best].frames;
        end else begin
          keep = live_total();
          if (keep < MaxTracks) begin
            slots[keep] = '{x: cx, y: cy, ident: next_ident, frames: '0};
            live[keep] = 1'b1;
            matched[keep] = 1'b1;
            r.track_id = next_ident;
            r.is_new = 1'b1;
            next_ident = next_ident + 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
      end else begin
        live_prior = live_total();
        keep = 0;
        for (int i = 0; i < MaxTracks; i++) begin
          if (live[i] && matched[i]) begin
            slots[keep] = slots[i];
            live[keep] = 1'b1;
            matched[keep] = 1'b0;
            keep++;
          end
        end
        for (int i = keep; i < MaxTracks; i++) begin
          live[i] = 1'b0;
          matched[i] = 1'b0;
        end
        r.removed_count = 5'(live_prior - keep);
      end
      r.live_count = 5'(live_total());
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string name, logic [IdentW-1:0] want, logic [IdentW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(track_result_t got);
      track_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual track_id %0d live_count %0d",
                 $time, got.track_id, got.live_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("track_id", want.track_id, got.track_id);
      compare_field("is_new", IdentW'(want.is_new), IdentW'(got.is_new));
      compare_field("frames_seen", IdentW'(want.frames_seen), IdentW'(got.frames_seen));
      compare_field("table_full", IdentW'(want.table_full), IdentW'(got.table_full));
      compare_field("live_count", IdentW'(want.live_count), IdentW'(got.live_count));
      compare_field("removed_count", IdentW'(want.removed_count), IdentW'(got.removed_count));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CoordW-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               opcode_i;
  logic [CoordW-1:0]  centroid_x_i;
  logic [CoordW-1:0]  centroid_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IdentW-1:0]  track_id_o;
  logic               is_new_o;
  logic [FramesW-1:0] frames_seen_o;
  logic               table_full_o;
  logic [4:0]         live_count_o;
  logic [4:0]         removed_count_o;

  track_scoreboard sb;
  bit              burst_in;
  bit              burst_out;
  bit              long_hold;
  int              sent;
  int              obj_x[$];
  int              obj_y[$];

  nearest_centroid_blob_tracker_top uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    track_result_t got;
    if (cfg_we_i) sb.radius = cfg_data_i;
    if (in_valid_i && !in_stall_o) sb.note_request(opcode_i, centroid_x_i, centroid_y_i);
    if (out_valid_o && !out_stall_i) begin
      got.track_id = track_id_o;
      got.is_new = is_new_o;
      got.frames_seen = frames_seen_o;
      got.table_full = table_full_o;
      got.live_count = live_count_o;
      got.removed_count = removed_count_o;
      sb.check_result(got);
    end
  end

  function automatic logic [CoordW-1:0] nudge(int p, int j);
    int q;
    q = p + int'($urandom_range(0, 2 * j)) - j;
    if (q < 0) q = 0;
    if (q > CoordMax) q = CoordMax;
    return q[CoordW-1:0];
  endfunction

  task automatic send_request(input logic op, input logic [CoordW-1:0] x,
                              input logic [CoordW-1:0] y);
    int gap;
    if (sent % 40 == 0) burst_in = ($urandom_range(0, 3) == 0);
    gap = burst_in ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    centroid_x_i <= x;
    centroid_y_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [CoordW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_frames(input int budget, input int jitter);
    int stop;
    int k;
    stop = sent + budget;
    while (sent < stop) begin
      repeat ($urandom_range(0, 3)) begin
        if (obj_x.size() > 0) begin
          k = int'($urandom_range(0, obj_x.size() - 1));
          obj_x.delete(k);
          obj_y.delete(k);
        end
      end
      repeat ($urandom_range(0, 3)) begin
        if (obj_x.size() < 22) begin
          obj_x = {obj_x, int'($urandom_range(0, CoordMax))};
          obj_y = {obj_y, int'($urandom_range(0, CoordMax))};
        end
      end
      foreach (obj_x[i]) begin
        if ($urandom_range(0, 9) != 0) begin
          obj_x[i] = int'(nudge(obj_x[i], jitter));
          obj_y[i] = int'(nudge(obj_y[i], jitter));
          send_request(OpBlob, CoordW'(obj_x[i]), CoordW'(obj_y[i]));
        end
      end
      if ($urandom_range(0, 3) == 0)
        send_request(OpBlob, CoordW'($urandom_range(0, CoordMax)),
                     CoordW'($urandom_range(0, CoordMax)));
      // occasionally merge two frames or close one twice
      if ($urandom_range(0, 15) != 0)
        send_request(OpEndFrame, CoordW'($urandom), CoordW'($urandom));
      if ($urandom_range(0, 15) == 0)
        send_request(OpEndFrame, CoordW'($urandom), CoordW'($urandom));
    end
  endtask

  task automatic run_phase(input logic [CoordW-1:0] radius, input int jitter, input bit hold);
    write_radius(radius);
    long_hold = hold;
    run_frames(190, jitter);
    settle();
  endtask

  initial begin
    int r;
    sb = new();
    sent = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    opcode_i <= OpBlob;
    centroid_x_i <= '0;
    centroid_y_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_radius(RadiusReset);
    // frame 1: a tracker created this frame cannot be matched again
    send_request(OpBlob, CoordW'(0), CoordW'(0));
    send_request(OpBlob, CoordW'(CoordMax), CoordW'(CoordMax));
    send_request(OpBlob, CoordW'(200), CoordW'(0));
    send_request(OpEndFrame, CoordW'(0), CoordW'(0));
    // frame 2: equal distance to two trackers, the older one wins
    send_request(OpBlob, CoordW'(100), CoordW'(0));
    send_request(OpBlob, CoordW'(CoordMax), CoordW'(CoordMax));
    send_request(OpEndFrame, CoordW'(CoordMax), CoordW'(CoordMax));
    // frame 3: fill the table, last blobs dropped
    for (int k = 0; k < MaxTracks; k++) send_request(OpBlob, CoordW'(500 * k), CoordW'(4000));
    send_request(OpEndFrame, CoordW'(0), CoordW'(0));
    settle();

    run_phase(CoordW'(CoordMax), 2000, 1'b1);
    run_phase(CoordW'(0), 40, 1'b0);
    run_phase(RadiusReset, 500, 1'b0);
    r = int'($urandom_range(1, CoordMax - 1));
    run_phase(CoordW'(r), r / 3 + 1, 1'b1);
    run_phase(CoordW'(1), 2, 1'b0);
    r = int'($urandom_range(1, CoordMax - 1));
    run_phase(CoordW'(r), r / 2 + 1, 1'b0);

    repeat (25) @(posedge clk_i);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int stall_len;
    int taken;
    taken = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) burst_out = ($urandom_range(0, 3) == 0);
      if (long_hold) begin
        stall_len = 400;
        long_hold = 1'b0;
      end else begin
        stall_len = burst_out ? 0 : int'($urandom_range(0, 16));
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: nearest_centroid_blob_tracker_top.f
rtl/ncbt_pkg.sv
rtl/nearest_centroid_blob_tracker_top.sv
tb/tb_top.sv
